>>> rtl/core/rsss_pkg.sv
package rsss_pkg;

  // Field widths
  localparam int RANGE_W  = 8;
  localparam int STATUS_W = 4;
  localparam int MEAN_W   = 16;
  localparam int SD_W     = 15;
  localparam int ERR_W    = 4;
  localparam int SLOT_W   = 8;
  localparam int COUNT_W  = 8;

  // Datapath widths
  localparam int SUM_W      = 16;
  localparam int SUMSQ_W    = 24;
  localparam int PROD_W     = 32;
  localparam int NN_W       = 16;
  localparam int MEAN_FRAC  = 8;
  localparam int VAR_FRAC   = 16;
  localparam int ROOT_W     = 16;
  localparam int ROOT_REM_W = ROOT_W + 1;
  localparam int STEP_CNT_W = 4;

  localparam int SLOT_COUNT_DEF = 200;
  localparam logic [COUNT_W-1:0] SAMPLE_COUNT_RST = 8'd20;

  // Sensor status codes
  localparam logic [STATUS_W-1:0] STAT_VALID     = 4'd0;
  localparam logic [STATUS_W-1:0] STAT_SYS_FIRST = 4'd1;
  localparam logic [STATUS_W-1:0] STAT_SYS_LAST  = 4'd5;
  localparam logic [STATUS_W-1:0] STAT_ECE       = 4'd6;
  localparam logic [STATUS_W-1:0] STAT_NOCONV    = 4'd7;
  localparam logic [STATUS_W-1:0] STAT_IGNORE    = 4'd8;
  localparam logic [STATUS_W-1:0] STAT_SNR       = 4'd11;
  localparam logic [STATUS_W-1:0] STAT_RAW_UFL   = 4'd12;
  localparam logic [STATUS_W-1:0] STAT_RAW_OFL   = 4'd13;
  localparam logic [STATUS_W-1:0] STAT_RNG_UFL   = 4'd14;
  localparam logic [STATUS_W-1:0] STAT_RNG_OFL   = 4'd15;

  // Error kinds reported with a set
  localparam logic [ERR_W-1:0] ERR_NONE    = 4'd0;
  localparam logic [ERR_W-1:0] ERR_SYSTEM  = 4'd1;
  localparam logic [ERR_W-1:0] ERR_ECE     = 4'd2;
  localparam logic [ERR_W-1:0] ERR_NOCONV  = 4'd3;
  localparam logic [ERR_W-1:0] ERR_IGNORE  = 4'd4;
  localparam logic [ERR_W-1:0] ERR_SNR     = 4'd5;
  localparam logic [ERR_W-1:0] ERR_RAW_UFL = 4'd6;
  localparam logic [ERR_W-1:0] ERR_RAW_OFL = 4'd7;
  localparam logic [ERR_W-1:0] ERR_RNG_UFL = 4'd8;
  localparam logic [ERR_W-1:0] ERR_RNG_OFL = 4'd9;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_MUL,
    ST_DIFF,
    ST_DIV,
    ST_SQRT,
    ST_DONE
  } rsss_state_e;

  // Map a sensor status to an error kind; valid and unassigned codes keep prev.
  function automatic logic [ERR_W-1:0] error_of_status(input logic [STATUS_W-1:0] st,
                                                       input logic [ERR_W-1:0]    prev);
    logic [ERR_W-1:0] e;
    e = prev;
    if (st >= STAT_SYS_FIRST && st <= STAT_SYS_LAST) begin
      e = ERR_SYSTEM;
    end else begin
      case (st)
        STAT_ECE:     e = ERR_ECE;
        STAT_NOCONV:  e = ERR_NOCONV;
        STAT_IGNORE:  e = ERR_IGNORE;
        STAT_SNR:     e = ERR_SNR;
        STAT_RAW_UFL: e = ERR_RAW_UFL;
        STAT_RAW_OFL: e = ERR_RAW_OFL;
        STAT_RNG_UFL: e = ERR_RNG_UFL;
        STAT_RNG_OFL: e = ERR_RNG_OFL;
        default:      e = prev;
      endcase
    end
    return e;
  endfunction

endpackage

>>> rtl/core/rsss_in_if.sv
interface rsss_in_if import rsss_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [RANGE_W-1:0]  range_mm;
  logic [STATUS_W-1:0] range_status;

  modport source (output valid, output range_mm, output range_status, input ready);
  modport sink   (input valid, input range_mm, input range_status, output ready);
endinterface

>>> rtl/core/rsss_out_if.sv
interface rsss_out_if import rsss_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MEAN_W-1:0] mean_q8;
  logic [SD_W-1:0]   std_dev_q8;
  logic [ERR_W-1:0]  error_kind;
  logic [SLOT_W-1:0] slot_index;

  modport source (output valid, output mean_q8, output std_dev_q8, output error_kind,
                  output slot_index, input ready);
  modport sink   (input valid, input mean_q8, input std_dev_q8, input error_kind,
                  input slot_index, output ready);
endinterface

>>> rtl/core/rsss_serdiv.sv
// Restoring divider, one quotient bit per cycle.
module rsss_serdiv import rsss_pkg::*; #(
  parameter int NUM_W = 24,
  parameter int DEN_W = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] dividend_i,
  input  logic [DEN_W-1:0] divisor_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quotient_o
);

  localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem_q, num_q[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = dividend_i;
      rem_d  = '0;
      den_d  = divisor_i;
    end else if (busy_q) begin
      num_d = {num_q[NUM_W-2:0], fits};
      rem_d = fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(NUM_W - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = num_q;

endmodule

>>> rtl/core/range_sample_set_statistics.sv
// Range sample set statistics.
// sample_i carries one word per range reading (range_mm, range_status);
// result_o carries one word per closed set (mean_q8, std_dev_q8,
// error_kind, slot_index). Both channels complete on valid && ready.
// cfg_we_i / cfg_wdata_i write the set size; write it only while idle.
// A sample that does not close its set passes through the bit-serial
// squarer, then ready rises again.
// The closing sample passes, from acceptance to result_o.valid, through
// the bit-serial squarer, the serial products n*sumsq, sum*sum and n*n,
// a step to form the variance numerator, the 48-bit restoring divide
// (the mean divide runs alongside it), the square root at two input
// bits per step, and the load of the output register.
// Reset clears the set, the slot index and the output valid, and sets
// the set size to 20. The result sits in an output register: a stalled
// receiver does not stop the next set from filling; only a second result
// finishing while the first is still held waits in the done state.
module range_sample_set_statistics import rsss_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [COUNT_W-1:0] cfg_wdata_i,
  rsss_in_if.sink            sample_i,
  rsss_out_if.source         result_o
);

  localparam int MNUM_W = SUM_W + MEAN_FRAC;
  localparam int VNUM_W = PROD_W + VAR_FRAC;

  rsss_state_e state_q, state_d;
  logic [STEP_CNT_W-1:0] cnt_q, cnt_d;

  // Set state
  logic [COUNT_W-1:0] sample_count_q, sample_count_d;
  logic [COUNT_W-1:0] taken_q, taken_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [SUMSQ_W-1:0] sumsq_q, sumsq_d;
  logic [ERR_W-1:0]   set_err_q, set_err_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;

  // Snapshot of the closing set
  logic               close_q, close_d;
  logic [COUNT_W-1:0] n_q, n_d;
  logic [ERR_W-1:0]   res_err_q, res_err_d;

  // Bit-serial squarer
  logic [2*RANGE_W-1:0] sq_mcand_q, sq_mcand_d;
  logic [RANGE_W-1:0]   sq_mplier_q, sq_mplier_d;

  // Bit-serial products
  logic [PROD_W-1:0]  a_acc_q, a_acc_d, a_mcand_q, a_mcand_d;
  logic [COUNT_W-1:0] n_mplier_q, n_mplier_d;
  logic [PROD_W-1:0]  b_acc_q, b_acc_d, b_mcand_q, b_mcand_d;
  logic [SUM_W-1:0]   b_mplier_q, b_mplier_d;
  logic [NN_W-1:0]    nn_acc_q, nn_acc_d, nn_mcand_q, nn_mcand_d;

  // Square root
  logic [PROD_W-1:0]     src_q, src_d;
  logic [ROOT_REM_W-1:0] srem_q, srem_d;
  logic [ROOT_W-1:0]     root_q, root_d;
  logic [ROOT_REM_W+1:0] rt_trial, rt_sub;

  // Output register
  logic              out_valid_q, out_valid_d;
  logic [MEAN_W-1:0] out_mean_q, out_mean_d;
  logic [SD_W-1:0]   out_sd_q, out_sd_d;
  logic [ERR_W-1:0]  out_err_q, out_err_d;
  logic [SLOT_W-1:0] out_slot_q, out_slot_d;

  // Input side
  logic               in_acc;
  logic [RANGE_W-1:0] val;
  logic [ERR_W-1:0]   err_nx;
  logic [COUNT_W-1:0] n_nx, target;
  logic [SLOT_W:0]    slot_inc;
  logic [SLOT_W-1:0]  slot_nx;
  logic [PROD_W-1:0]  diff;

  // Dividers
  logic              div_start;
  logic              mean_busy, var_busy;
  logic [MNUM_W-1:0] mean_quot;
  logic [VNUM_W-1:0] var_quot;

  assign sample_i.ready = (state_q == ST_IDLE);
  assign in_acc = sample_i.valid && sample_i.ready;

  assign val    = (sample_i.range_status == STAT_VALID) ? sample_i.range_mm : '0;
  assign err_nx = (sample_i.range_status == STAT_VALID) ? set_err_q
                : error_of_status(sample_i.range_status, set_err_q);
  assign n_nx   = taken_q + 1'b1;
  assign target = (sample_count_q == '0) ? COUNT_W'(1) : sample_count_q;

  // Advance the slot and wrap it at the slot count
  assign slot_inc = {1'b0, slot_q} + 1'b1;
  assign slot_nx  = (slot_inc >= (SLOT_W + 1)'(SLOT_COUNT)) ? '0 : slot_inc[SLOT_W-1:0];

  // n*sumsq never falls below sum^2; clamp anyway
  assign diff = (a_acc_q > b_acc_q) ? (a_acc_q - b_acc_q) : '0;

  // One root digit: bring in two bits, try (root << 2) | 1
  assign rt_trial = {srem_q, src_q[PROD_W-1 -: 2]};
  assign rt_sub   = {1'b0, root_q, 2'b01};

  assign div_start = (state_q == ST_DIFF);

  rsss_serdiv #(
    .NUM_W(MNUM_W),
    .DEN_W(COUNT_W)
  ) u_mean_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i({sum_q, MEAN_FRAC'(0)}),
    .divisor_i (n_q),
    .busy_o    (mean_busy),
    .quotient_o(mean_quot)
  );

  rsss_serdiv #(
    .NUM_W(VNUM_W),
    .DEN_W(NN_W)
  ) u_var_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i({diff, VAR_FRAC'(0)}),
    .divisor_i (nn_acc_q),
    .busy_o    (var_busy),
    .quotient_o(var_quot)
  );

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    sample_count_d = sample_count_q;
    taken_d        = taken_q;
    sum_d          = sum_q;
    sumsq_d        = sumsq_q;
    set_err_d      = set_err_q;
    slot_d         = slot_q;
    close_d        = close_q;
    n_d            = n_q;
    res_err_d      = res_err_q;
    sq_mcand_d     = sq_mcand_q;
    sq_mplier_d    = sq_mplier_q;
    a_acc_d        = a_acc_q;
    a_mcand_d      = a_mcand_q;
    n_mplier_d     = n_mplier_q;
    b_acc_d        = b_acc_q;
    b_mcand_d      = b_mcand_q;
    b_mplier_d     = b_mplier_q;
    nn_acc_d       = nn_acc_q;
    nn_mcand_d     = nn_mcand_q;
    src_d          = src_q;
    srem_d         = srem_q;
    root_d         = root_q;
    out_valid_d    = out_valid_q;
    out_mean_d     = out_mean_q;
    out_sd_d       = out_sd_q;
    out_err_d      = out_err_q;
    out_slot_d     = out_slot_q;

    if (cfg_we_i) begin
      sample_count_d = cfg_wdata_i;
    end

    // Drop the held word once taken
    if (out_valid_q && result_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          sum_d       = sum_q + SUM_W'(val);
          taken_d     = n_nx;
          set_err_d   = err_nx;
          n_d         = n_nx;
          res_err_d   = err_nx;
          close_d     = (n_nx >= target);
          sq_mcand_d  = (2*RANGE_W)'(val);
          sq_mplier_d = val;
          cnt_d       = '0;
          state_d     = ST_SQ;
        end
      end

      ST_SQ: begin
        if (sq_mplier_q[0]) begin
          sumsq_d = sumsq_q + SUMSQ_W'(sq_mcand_q);
        end
        sq_mcand_d  = {sq_mcand_q[2*RANGE_W-2:0], 1'b0};
        sq_mplier_d = {1'b0, sq_mplier_q[RANGE_W-1:1]};
        cnt_d       = cnt_q + 1'b1;
        if (cnt_q == STEP_CNT_W'(RANGE_W - 1)) begin
          cnt_d = '0;
          if (close_q) begin
            a_acc_d    = '0;
            a_mcand_d  = PROD_W'(sumsq_d);
            n_mplier_d = n_q;
            b_acc_d    = '0;
            b_mcand_d  = PROD_W'(sum_q);
            b_mplier_d = sum_q;
            nn_acc_d   = '0;
            nn_mcand_d = NN_W'(n_q);
            state_d    = ST_MUL;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_MUL: begin
        if (n_mplier_q[0]) begin
          a_acc_d  = a_acc_q + a_mcand_q;
          nn_acc_d = nn_acc_q + nn_mcand_q;
        end
        if (b_mplier_q[0]) begin
          b_acc_d = b_acc_q + b_mcand_q;
        end
        a_mcand_d  = {a_mcand_q[PROD_W-2:0], 1'b0};
        nn_mcand_d = {nn_mcand_q[NN_W-2:0], 1'b0};
        b_mcand_d  = {b_mcand_q[PROD_W-2:0], 1'b0};
        n_mplier_d = {1'b0, n_mplier_q[COUNT_W-1:1]};
        b_mplier_d = {1'b0, b_mplier_q[SUM_W-1:1]};
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == STEP_CNT_W'(SUM_W - 1)) begin
          state_d = ST_DIFF;
        end
      end

      ST_DIFF: begin
        // Dividers take their operands now; clear the set for the next one
        taken_d   = '0;
        sum_d     = '0;
        sumsq_d   = '0;
        set_err_d = ERR_NONE;
        state_d   = ST_DIV;
      end

      ST_DIV: begin
        if (!mean_busy && !var_busy) begin
          src_d   = var_quot[PROD_W-1:0];
          srem_d  = '0;
          root_d  = '0;
          cnt_d   = '0;
          state_d = ST_SQRT;
        end
      end

      ST_SQRT: begin
        if (rt_trial >= rt_sub) begin
          srem_d = ROOT_REM_W'(rt_trial - rt_sub);
          root_d = {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          srem_d = rt_trial[ROOT_REM_W-1:0];
          root_d = {root_q[ROOT_W-2:0], 1'b0};
        end
        src_d = {src_q[PROD_W-3:0], 2'b00};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == STEP_CNT_W'(ROOT_W - 1)) begin
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        // Hold until the output register is free
        if (!out_valid_q || result_o.ready) begin
          out_valid_d = 1'b1;
          out_mean_d  = mean_quot[MEAN_W-1:0];
          out_sd_d    = root_q[SD_W-1:0];
          out_err_d   = res_err_q;
          out_slot_d  = slot_nx;
          slot_d      = slot_nx;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      cnt_q          <= '0;
      sample_count_q <= SAMPLE_COUNT_RST;
      taken_q        <= '0;
      sum_q          <= '0;
      sumsq_q        <= '0;
      set_err_q      <= ERR_NONE;
      slot_q         <= '0;
      close_q        <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      cnt_q          <= cnt_d;
      sample_count_q <= sample_count_d;
      taken_q        <= taken_d;
      sum_q          <= sum_d;
      sumsq_q        <= sumsq_d;
      set_err_q      <= set_err_d;
      slot_q         <= slot_d;
      close_q        <= close_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q         <= n_d;
    res_err_q   <= res_err_d;
    sq_mcand_q  <= sq_mcand_d;
    sq_mplier_q <= sq_mplier_d;
    a_acc_q     <= a_acc_d;
    a_mcand_q   <= a_mcand_d;
    n_mplier_q  <= n_mplier_d;
    b_acc_q     <= b_acc_d;
    b_mcand_q   <= b_mcand_d;
    b_mplier_q  <= b_mplier_d;
    nn_acc_q    <= nn_acc_d;
    nn_mcand_q  <= nn_mcand_d;
    src_q       <= src_d;
    srem_q      <= srem_d;
    root_q      <= root_d;
    out_mean_q  <= out_mean_d;
    out_sd_q    <= out_sd_d;
    out_err_q   <= out_err_d;
    out_slot_q  <= out_slot_d;
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.mean_q8    = out_mean_q;
  assign result_o.std_dev_q8 = out_sd_q;
  assign result_o.error_kind = out_err_q;
  assign result_o.slot_index = out_slot_q;

endmodule

>>> rtl/core/rsss_checker.sv
module rsss_checker import rsss_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [ERR_W-1:0]  error_kind_i,
  input logic [SLOT_W-1:0] slot_index_i
);

  // A stalled result word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  // Slot index wraps below the slot count
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ({1'b0, slot_index_i} < (SLOT_W + 1)'(SLOT_COUNT)))
    else $error("slot index beyond slot count");

  // Only defined error kinds leave the block
  a_err_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (error_kind_i <= ERR_RNG_OFL))
    else $error("undefined error kind");

  // The serial squarer keeps the input closed after each sample
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("sample taken while squarer busy");

endmodule

bind range_sample_set_statistics rsss_checker #(
  .SLOT_COUNT(SLOT_COUNT)
) u_rsss_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (sample_i.valid),
  .in_ready_i  (sample_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .error_kind_i(result_o.error_kind),
  .slot_index_i(result_o.slot_index)
);

>>> dv/rsss_stats_checker.sv
`timescale 1ns / 100ps
module rsss_stats_checker import rsss_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [COUNT_W-1:0] cfg_wdata_i,
  rsss_in_if                 sample_i,
  rsss_out_if                result_i,
  output int                 mismatch_count_o,
  output int                 sets_outstanding_o
);

  typedef struct packed {
    logic [MEAN_W-1:0] mean_q8;
    logic [SD_W-1:0]   std_dev_q8;
    logic [ERR_W-1:0]  error_kind;
    logic [SLOT_W-1:0] slot_index;
  } set_stats_t;

  // Mirror of the set state
  logic [COUNT_W-1:0] set_size;
  logic [COUNT_W-1:0] taken;
  logic [SUM_W-1:0]   sum_acc;
  logic [SUMSQ_W-1:0] sumsq_acc;
  logic [ERR_W-1:0]   last_error;
  logic [SLOT_W-1:0]  slot;
  set_stats_t         expected_sets[$];
  int                 sets_seen;

  function automatic logic [ERR_W-1:0] fault_kind(input logic [STATUS_W-1:0] st,
                                                  input logic [ERR_W-1:0]    held);
    if (st >= STAT_SYS_FIRST && st <= STAT_SYS_LAST) return ERR_SYSTEM;
    case (st)
      STAT_ECE:     return ERR_ECE;
      STAT_NOCONV:  return ERR_NOCONV;
      STAT_IGNORE:  return ERR_IGNORE;
      STAT_SNR:     return ERR_SNR;
      STAT_RAW_UFL: return ERR_RAW_UFL;
      STAT_RAW_OFL: return ERR_RAW_OFL;
      STAT_RNG_UFL: return ERR_RNG_UFL;
      STAT_RNG_OFL: return ERR_RNG_OFL;
      default:      return held;
    endcase
  endfunction

  // Bit-by-bit floor square root
  function automatic logic [31:0] floor_sqrt(input logic [63:0] x);
    logic [31:0] root;
    logic [31:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if (64'(trial) * 64'(trial) <= x) root = trial;
    end
    return root;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatch_count_o++;
    if (mismatch_count_o <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : predict
    logic [RANGE_W-1:0] sample_val;
    logic [COUNT_W-1:0] target;
    logic [63:0]        n64;
    logic [63:0]        mean64;
    logic [63:0]        a64;
    logic [63:0]        b64;
    logic [63:0]        diff64;
    logic [63:0]        q64;
    set_stats_t         want;
    set_stats_t         got;
    if (!rst_ni) begin
      set_size         = SAMPLE_COUNT_RST;
      taken            = '0;
      sum_acc          = '0;
      sumsq_acc        = '0;
      last_error       = ERR_NONE;
      slot             = '0;
      sets_seen        = 0;
      mismatch_count_o = 0;
      expected_sets.delete();
    end else begin
      // Compare a delivered set against the oldest prediction
      if (result_i.valid && result_i.ready) begin
        got.mean_q8    = result_i.mean_q8;
        got.std_dev_q8 = result_i.std_dev_q8;
        got.error_kind = result_i.error_kind;
        got.slot_index = result_i.slot_index;
        if (expected_sets.size() == 0) begin
          flag_mismatch($sformatf("unexpected result: mean %0d sd %0d err %0d slot %0d",
                                  got.mean_q8, got.std_dev_q8, got.error_kind,
                                  got.slot_index));
        end else begin
          want = expected_sets.pop_front();
          if (got !== want) begin
            flag_mismatch($sformatf({"set %0d: expected mean %0d sd %0d err %0d slot %0d,",
                                     " got mean %0d sd %0d err %0d slot %0d"},
                                    sets_seen, want.mean_q8, want.std_dev_q8,
                                    want.error_kind, want.slot_index, got.mean_q8,
                                    got.std_dev_q8, got.error_kind, got.slot_index));
          end
        end
        sets_seen++;
      end

      if (cfg_we_i) set_size = cfg_wdata_i;

      if (sample_i.valid && sample_i.ready) begin
        // A failing reading enters the set as zero
        sample_val = (sample_i.range_status == STAT_VALID) ? sample_i.range_mm : '0;
        if (sample_i.range_status != STAT_VALID) begin
          last_error = fault_kind(sample_i.range_status, last_error);
        end
        sum_acc   = sum_acc + SUM_W'(sample_val);
        sumsq_acc = sumsq_acc + SUMSQ_W'(sample_val) * SUMSQ_W'(sample_val);
        taken     = taken + 1'b1;
        target    = (set_size == '0) ? COUNT_W'(1) : set_size;
        if (taken == '0 || taken >= target) begin
          n64    = (taken == '0) ? 64'd256 : 64'(taken);
          mean64 = (64'(sum_acc) << MEAN_FRAC) / n64;
          a64    = n64 * 64'(sumsq_acc);
          b64    = 64'(sum_acc) * 64'(sum_acc);
          diff64 = (a64 > b64) ? a64 - b64 : '0;
          q64    = (diff64 << VAR_FRAC) / (n64 * n64);
          slot   = (int'(slot) + 1 >= SLOT_COUNT) ? '0 : slot + 1'b1;
          want.mean_q8    = mean64[MEAN_W-1:0];
          want.std_dev_q8 = SD_W'(floor_sqrt(q64));
          want.error_kind = last_error;
          want.slot_index = slot;
          expected_sets.push_back(want);
          taken      = '0;
          sum_acc    = '0;
          sumsq_acc  = '0;
          last_error = ERR_NONE;
        end
      end
    end
    sets_outstanding_o = expected_sets.size();
  end

endmodule

>>> dv/tb_range_sample_set_statistics.sv
`timescale 1ns / 100ps
module tb_range_sample_set_statistics;
  import rsss_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 9;
  localparam int RANDOM_WORDS = 1500;
  // A closing sample takes longer than a plain one; drain a bit past it.
  localparam int DRAIN_CYCLES = 100;
  // Longest quiet stretch in a good run: the longest sender gap or
  // receiver stall on top of the closing computation.
  localparam int QUIET_LIMIT  = 4000;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BLOCK} rx_mode_e;
  typedef enum int {
    PAT_MIXED, PAT_FULL_SCALE, PAT_ALTERNATE, PAT_FAULTY, PAT_CLUSTER
  } word_pattern_e;

  logic               clk_i     = 1'b0;
  logic               rst_ni    = 1'b0;
  logic               cfg_we    = 1'b0;
  logic [COUNT_W-1:0] cfg_wdata = '0;
  int                 mismatch_count;
  int                 sets_outstanding;
  int                 quiet_cycles  = 0;
  int                 random_words  = 0;
  rx_mode_e           rx_mode       = RX_OPEN;
  int                 rx_mode_left  = 0;

  rsss_in_if  sample_ch();
  rsss_out_if result_ch();

  always #CLK_HALF clk_i = ~clk_i;

  range_sample_set_statistics dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .sample_i   (sample_ch),
    .result_o   (result_ch)
  );

  rsss_stats_checker stats_chk (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we),
    .cfg_wdata_i       (cfg_wdata),
    .sample_i          (sample_ch),
    .result_i          (result_ch),
    .mismatch_count_o  (mismatch_count),
    .sets_outstanding_o(sets_outstanding)
  );

  // Receiver: switch between stall modes at random intervals so that
  // backpressure lands on every phase of the computation, including long
  // open stretches with no stall at all.
  always @(negedge clk_i) begin
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_e'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(20, 200);
    end
    rx_mode_left--;
    case (rx_mode)
      RX_OPEN:   result_ch.ready <= rst_ni;
      RX_COIN:   result_ch.ready <= rst_ni && ($urandom_range(0, 1) == 0);
      RX_SPARSE: result_ch.ready <= rst_ni && ($urandom_range(0, 7) == 0);
      // hold ready low for the whole stretch, open for its last cycle
      default:   result_ch.ready <= rst_ni && (rx_mode_left == 0);
    endcase
  end

  // Watchdog: reset the count on any accepted word on either channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (sample_ch.valid && sample_ch.ready) ||
        (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("range_sample_set_statistics verification failed");
    $finish;
  end

  // Present one word at the falling edge and hold it until accepted.
  // Valid stays high on return, so a following word keeps it high.
  task automatic push_word(input logic [RANGE_W-1:0] rng, input logic [STATUS_W-1:0] st);
    @(negedge clk_i);
    sample_ch.valid        <= 1'b1;
    sample_ch.range_mm     <= rng;
    sample_ch.range_status <= st;
    do @(posedge clk_i); while (!sample_ch.ready);
  endtask

  // Drop valid for the given number of cycles.
  task automatic pause_words(input int cycles);
    @(negedge clk_i);
    sample_ch.valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // Stop sending, wait for every predicted set to come out, then let the
  // block finish any non-closing sample still in its squarer.
  task automatic drain_sets();
    pause_words(1);
    while (sets_outstanding != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Write the set size while the block is idle.
  task automatic write_set_size(input logic [COUNT_W-1:0] size_val);
    drain_sets();
    cfg_wdata <= size_val;
    cfg_we    <= 1'b1;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // Send a run of words of one flavor in bursts with random gaps.
  task automatic send_phase(input int words, input word_pattern_e pattern);
    int                  burst_left;
    int                  gap_pick;
    logic [RANGE_W-1:0]  base;
    logic [RANGE_W-1:0]  rng;
    logic [STATUS_W-1:0] st;
    burst_left = $urandom_range(1, 16);
    base       = RANGE_W'($urandom_range(0, 255));
    for (int k = 0; k < words; k++) begin
      rng = RANGE_W'($urandom_range(0, 255));
      st  = STAT_VALID;
      case (pattern)
        PAT_FULL_SCALE: rng = '1;
        PAT_ALTERNATE:  rng = k[0] ? '1 : '0;
        PAT_FAULTY: begin
          if ($urandom_range(0, 4) != 0) begin
            st = STATUS_W'($urandom_range(STAT_SYS_FIRST, STAT_RNG_OFL));
          end
        end
        PAT_CLUSTER: begin
          rng = base + RANGE_W'($urandom_range(0, 7));
          if ($urandom_range(0, 9) == 0) begin
            st = STATUS_W'($urandom_range(STAT_SYS_FIRST, STAT_RNG_OFL));
          end
        end
        default: begin
          if ($urandom_range(0, 3) == 0) begin
            st = STATUS_W'($urandom_range(STAT_SYS_FIRST, STAT_RNG_OFL));
          end
        end
      endcase
      push_word(rng, st);
      random_words++;
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap_pick   = $urandom_range(0, 39);
        if (gap_pick == 0) begin
          // hold off until every closed set has been delivered
          pause_words(1);
          while (sets_outstanding != 0) @(negedge clk_i);
        end else if (gap_pick < 16) begin
          // next burst follows at once
        end else if (gap_pick < 32) begin
          pause_words($urandom_range(1, 12));
        end else if (gap_pick < 38) begin
          pause_words($urandom_range(13, 100));
        end else begin
          pause_words($urandom_range(101, 300));
        end
      end
    end
  endtask

  initial begin
    logic [COUNT_W-1:0] size_val;
    int                 eff_size;
    int                 words;
    int                 pick;
    int                 phase;
    word_pattern_e      pattern;

    sample_ch.valid        = 1'b0;
    sample_ch.range_mm     = '0;
    sample_ch.range_status = STAT_VALID;
    result_ch.ready        = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: one set at the reset size of 20. Sweep every status code
    // with full-scale and zero ranges; the unassigned codes nine and ten
    // fall between assigned ones and must leave the error kind alone.
    for (int s = STAT_VALID; s <= STAT_RNG_OFL; s++) begin
      push_word((s % 2 == 0) ? 8'hFF : 8'h00, STATUS_W'(s));
    end
    push_word(8'hFF, STAT_VALID);
    push_word(8'h00, STAT_VALID);
    push_word(8'h7F, STAT_VALID);
    // unassigned code closes the set: error kind stays at range overflow
    push_word(8'h01, STAT_SNR - 4'd1);

    // Leave a partial set, then lower the size below it: the next word
    // closes a set of three.
    push_word(8'h80, STAT_VALID);
    push_word(8'h01, STAT_NOCONV);
    write_set_size(8'd1);
    push_word(8'hFF, STAT_VALID);
    push_word(8'h00, STAT_VALID);
    push_word(8'hFF, STAT_RNG_UFL);

    // Size zero acts as one.
    write_set_size(8'd0);
    push_word(8'hFF, STAT_VALID);
    push_word(8'h55, STAT_SYS_LAST);

    // Random phases. Open with the largest sets at both extremes of the
    // spread, then mostly small sets so results stay plentiful.
    phase = 0;
    while (random_words < RANDOM_WORDS) begin
      if (phase == 0) begin
        size_val = '1;
        pattern  = PAT_FULL_SCALE;
      end else if (phase == 1) begin
        size_val = '1;
        pattern  = PAT_ALTERNATE;
      end else begin
        pick = $urandom_range(0, 59);
        if (pick == 0) size_val = '0;
        else if (pick == 1) size_val = '1;
        else if (pick <= 4) size_val = SAMPLE_COUNT_RST;
        else if (pick <= 12) size_val = COUNT_W'($urandom_range(9, 64));
        else size_val = COUNT_W'($urandom_range(1, 8));
        pattern = word_pattern_e'($urandom_range(0, 4));
      end
      write_set_size(size_val);
      eff_size = (size_val == '0) ? 1 : int'(size_val);
      // leave a partial set behind so the next size change lands mid-set
      if (eff_size > 64) words = eff_size + $urandom_range(0, 8);
      else words = eff_size * $urandom_range(1, 4) + $urandom_range(0, eff_size - 1);
      send_phase(words, pattern);
      phase++;
    end

    drain_sets();
    if (mismatch_count == 0 && sets_outstanding == 0) begin
      $display("range_sample_set_statistics verification clean");
    end else begin
      $display("range_sample_set_statistics verification failed");
    end
    $finish;
  end

endmodule
